// ----- rtl/knb_pkg.sv -----
// Shared widths, codes, saturation limits and control types for the k-mer classifier.
`default_nettype none
package knb_pkg;

    localparam int FUNC_W = 1;
    localparam int ROW_W  = 6;
    localparam int KMER_W = 13;
    localparam int PROB_W = 32;
    localparam int SUM_W  = 48;
    localparam int BEST_W = 7;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic issue;
        logic fresh;
        logic col_ok;
    } t_acc_ctl;

endpackage
`default_nettype wire

// ----- rtl/knb_channels.sv -----
// Valid/ready channel interfaces for the classifier's input and result streams.
`default_nettype none
interface knb_in_if import knb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [ROW_W-1:0]         class_row;
    logic [KMER_W-1:0]        kmer_index;
    logic signed [PROB_W-1:0] prob_value;
    logic                     last;

    modport source (output valid, output func, output class_row, output kmer_index,
                    output prob_value, output last, input ready);
    modport sink   (input valid, input func, input class_row, input kmer_index,
                    input prob_value, input last, output ready);
endinterface

interface knb_out_if import knb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BEST_W-1:0] best_class;

    modport source (output valid, output best_class, input ready);
    modport sink   (input valid, input best_class, output ready);
endinterface
`default_nettype wire

// ----- rtl/knb_table_ram.sv -----
// Log-probability table: one write port, one registered read port.
`default_nettype none
module knb_table_ram import knb_pkg::*; #(
    parameter int DEPTH = 262144
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]        i_wr_addr,
    input  wire logic signed [PROB_W-1:0]        i_wr_data,
    input  wire logic                            i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]        i_rd_addr,
    output logic signed [PROB_W-1:0]             o_rd_data
);

    logic signed [PROB_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/knb_accum.sv -----
// Shared saturating accumulate unit with class-sum memory and running argmax.
`default_nettype none
module knb_accum import knb_pkg::*; #(
    parameter int NUM_CLASSES = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_acc_ctl                         i_ctl,
    input  wire logic [$clog2(NUM_CLASSES)-1:0]   i_cls,
    input  wire logic signed [PROB_W-1:0]         i_tab_data,
    output logic                                  o_done,
    output logic [$clog2(NUM_CLASSES)-1:0]        o_best_idx
);

    localparam int CLS_W = $clog2(NUM_CLASSES);
    localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(NUM_CLASSES - 1);

    logic signed [SUM_W-1:0]  r_sums [NUM_CLASSES];
    logic signed [SUM_W-1:0]  r_rd_sum;
    logic                     r_v1;
    logic [CLS_W-1:0]         r_cls1;
    logic                     r_v2;
    logic [CLS_W-1:0]         r_cls2;
    logic signed [SUM_W-1:0]  r_new;
    logic signed [SUM_W-1:0]  r_best;
    logic [CLS_W-1:0]         r_best_idx;
    logic                     r_done;

    logic signed [SUM_W-1:0]  w_acc;
    logic signed [PROB_W-1:0] w_add;
    logic signed [SUM_W:0]    w_ext;
    logic signed [SUM_W-1:0]  w_sat;

    // fresh: sums are logically zero since reset or the last query end
    assign w_acc = i_ctl.fresh ? '0 : r_rd_sum;
    assign w_add = i_ctl.col_ok ? i_tab_data : '0;
    assign w_ext = (SUM_W+1)'(w_acc) + (SUM_W+1)'(w_add);

    always_comb begin
        if (w_ext[SUM_W] != w_ext[SUM_W-1]) begin
            w_sat = w_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sat = w_ext[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_sums[r_cls1] <= w_sat;
        end
        if (i_ctl.issue) begin
            r_rd_sum <= r_sums[i_cls];
        end
        r_cls1 <= i_cls;
        r_cls2 <= r_cls1;
        r_new  <= w_sat;
        if (r_v2 && (r_cls2 == '0 || r_new > r_best)) begin
            r_best     <= r_new;
            r_best_idx <= r_cls2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_ctl.issue;
            r_v2   <= r_v1;
            r_done <= r_v2 && (r_cls2 == LAST_CLS);
        end
    end

    assign o_done     = r_done;
    assign o_best_idx = r_best_idx;

endmodule
`default_nettype wire

// ----- rtl/kmer_naive_bayes_classifier_unit.sv -----
// Top level: k-mer naive Bayes classifier with table load, accumulate and argmax.
// A table write (func 0) with a row and kmer in range is stored on its transfer.
// A query kmer (func 1) walks all classes through one shared saturating adder,
// one class per cycle, reading the table and the class-sum memory in step. The
// input is not ready again until the pass has left the accumulate pipeline, so
// that single accumulate port sets the pace of the queries. The argmax
// runs alongside the same walk, so the kmer marked last costs no extra pass.
// The result sits in an output register; a new item is taken while it waits,
// and only a later last kmer stalls until that register is free. There is no
// clearing pass after reset: the table is undefined until written.
`default_nettype none
module kmer_naive_bayes_classifier_unit import knb_pkg::*; #(
    parameter int NUM_CLASSES = 64,
    parameter int NUM_KMERS   = 4096
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    knb_in_if.sink        i_in,
    knb_out_if.source     o_out
);

    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int COL_W  = $clog2(NUM_KMERS);
    localparam int DEPTH  = NUM_CLASSES * NUM_KMERS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = (CLS_W + 1 > BEST_W) ? CLS_W + 1 : BEST_W;
    localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(NUM_CLASSES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } t_state;

    t_state                   r_state;
    logic [CLS_W-1:0]         r_cls;
    logic [ADDR_W-1:0]        r_rd_addr;
    logic                     r_col_ok;
    logic                     r_last;
    logic                     r_fresh;
    logic                     r_out_valid;
    logic [BEST_W-1:0]        r_best_class;

    logic                     w_accept;
    logic                     w_kmer_ok;
    logic                     w_row_ok;
    logic [KMER_W-1:0]        w_km1;
    logic [COL_W-1:0]         w_col;
    logic [ADDR_W-1:0]        w_wr_addr;
    logic                     w_wr_en;
    logic signed [PROB_W-1:0] w_tab_data;
    t_acc_ctl                 w_ctl;
    logic                     w_done;
    logic [CLS_W-1:0]         w_best_idx;
    logic [IDX_W-1:0]         w_best_ext;
    logic                     w_out_free;
    logic                     w_out_load;

    assign w_accept  = i_in.valid && i_in.ready;
    assign w_kmer_ok = (i_in.kmer_index != '0) &&
                       (32'(i_in.kmer_index) <= 32'(NUM_KMERS));
    assign w_row_ok  = 32'(i_in.class_row) < 32'(NUM_CLASSES);
    assign w_km1     = i_in.kmer_index - KMER_W'(1);
    assign w_col     = COL_W'(w_km1);
    assign w_wr_addr = ADDR_W'(i_in.class_row) * ADDR_W'(NUM_KMERS) + ADDR_W'(w_col);
    assign w_wr_en   = w_accept && (i_in.func == FUNC_WRITE) && w_kmer_ok && w_row_ok;

    assign w_ctl.issue  = (r_state == ST_RUN);
    assign w_ctl.fresh  = r_fresh;
    assign w_ctl.col_ok = r_col_ok;

    assign w_best_ext = IDX_W'(w_best_idx) + IDX_W'(1);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_load = ((r_state == ST_DRAIN) && w_done && r_last && w_out_free) ||
                        ((r_state == ST_HOLD) && w_out_free);

    knb_table_ram #(
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_in.prob_value),
        .i_rd_en   (w_ctl.issue),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (w_tab_data)
    );

    knb_accum #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_cls      (r_cls),
        .i_tab_data (w_tab_data),
        .o_done     (w_done),
        .o_best_idx (w_best_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_in.func == FUNC_QUERY) begin
                        r_cls     <= '0;
                        r_rd_addr <= w_kmer_ok ? ADDR_W'(w_col) : '0;
                        r_col_ok  <= w_kmer_ok;
                        r_last    <= i_in.last;
                        r_state   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_cls     <= r_cls + CLS_W'(1);
                    r_rd_addr <= r_rd_addr + ADDR_W'(NUM_KMERS);
                    if (r_cls == LAST_CLS) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_done) begin
                        r_fresh <= r_last;
                        if (!r_last) begin
                            r_state <= ST_IDLE;
                        end else if (w_out_free) begin
                            r_best_class <= w_best_ext[BEST_W-1:0];
                            r_state      <= ST_IDLE;
                        end else begin
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_best_class <= w_best_ext[BEST_W-1:0];
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.best_class = r_best_class;

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == ST_DRAIN)
        else $error("accumulate pass finished outside drain");

    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.func == FUNC_QUERY) |=> !i_in.ready)
        else $error("ready while a query kmer is in flight");

    a_hold_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HOLD |-> r_out_valid)
        else $error("holding a result with the output register empty");

    a_nonlast_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !r_last) |=> (r_state == ST_IDLE && !$rose(r_out_valid)))
        else $error("non-last kmer produced a transfer or stalled");

endmodule
`default_nettype wire

// ----- sim/tb_kmer_naive_bayes_classifier_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the k-mer naive Bayes classifier: table loads, queries, argmax.
module tb_kmer_naive_bayes_classifier_unit;
    import knb_pkg::*;

    localparam int NUM_CLASSES    = 64;
    localparam int NUM_KMERS      = 4096;
    localparam int CLK_PERIOD     = 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RX_HOLD_CYCLES = 1500;
    localparam int RAND_ITEMS     = 1450;
    localparam int SETTLE_CYCLES  = 2 * NUM_CLASSES + 16;
    localparam int KMER_MAX_CODE  = (1 << KMER_W) - 1;
    localparam longint SUM_HI     = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO     = -SUM_HI - 1;

    typedef enum int {
        PAT_ZERO,
        PAT_PEAK_LAST,
        PAT_MIN_TIE,
        PAT_ALT,
        PAT_RAND_FULL,
        PAT_RAND_SMALL,
        PAT_EXTREME,
        PAT_FLAT
    } t_col_pattern;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic [ROW_W-1:0]         class_row;
        logic [KMER_W-1:0]        kmer_index;
        logic signed [PROB_W-1:0] prob_value;
        logic                     last;
    } t_kmer_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    knb_in_if  in_if ();
    knb_out_if out_if ();

    kmer_naive_bayes_classifier_unit #(
        .NUM_CLASSES(NUM_CLASSES),
        .NUM_KMERS  (NUM_KMERS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    int                prob_tbl    [NUM_CLASSES * NUM_KMERS];
    bit                tbl_written [NUM_CLASSES * NUM_KMERS];
    int                col_fill    [NUM_KMERS];
    int                full_cols   [$];
    longint            class_sums  [NUM_CLASSES];
    logic [BEST_W-1:0] best_class_q [$];
    int                err_cnt     = 0;
    int                idle_cycles = 0;
    bit                idle_on     = 1'b1;
    bit                rx_hold_req = 1'b0;

    // Table update, saturating accumulate and first-max argmax for one accepted item.
    task automatic bayes_predict(input t_kmer_item it);
        int     col;
        int     slot;
        int     top_idx;
        bit     col_ok;
        longint acc;
        longint top;
        col_ok = it.kmer_index >= 1 && it.kmer_index <= NUM_KMERS;
        col    = col_ok ? int'(it.kmer_index) - 1 : 0;
        if (it.func == FUNC_WRITE) begin
            if (col_ok && it.class_row < NUM_CLASSES) begin
                slot = int'(it.class_row) * NUM_KMERS + col;
                prob_tbl[slot] = it.prob_value;
                if (!tbl_written[slot]) begin
                    tbl_written[slot] = 1'b1;
                    col_fill[col]++;
                    if (col_fill[col] == NUM_CLASSES)
                        full_cols.push_back(col + 1);
                end
            end
        end else begin
            if (col_ok) begin
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    acc = class_sums[c] + longint'(prob_tbl[c * NUM_KMERS + col]);
                    if (acc > SUM_HI)
                        acc = SUM_HI;
                    else if (acc < SUM_LO)
                        acc = SUM_LO;
                    class_sums[c] = acc;
                end
            end
            if (it.last) begin
                top     = class_sums[0];
                top_idx = 0;
                for (int c = 1; c < NUM_CLASSES; c++) begin
                    if (class_sums[c] > top) begin
                        top     = class_sums[c];
                        top_idx = c;
                    end
                end
                best_class_q.push_back(BEST_W'(top_idx + 1));
                for (int c = 0; c < NUM_CLASSES; c++)
                    class_sums[c] = 0;
            end
        end
    endtask

    task automatic send_item(input t_kmer_item it);
        while (idle_on && $urandom_range(99) < 18) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.func       <= it.func;
        in_if.class_row  <= it.class_row;
        in_if.kmer_index <= it.kmer_index;
        in_if.prob_value <= it.prob_value;
        in_if.last       <= it.last;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        bayes_predict(it);
        @(negedge i_clk);
    endtask

    task automatic send_write(input int row, input int kmer, input int value, input bit last);
        t_kmer_item it;
        it.func       = FUNC_WRITE;
        it.class_row  = ROW_W'(row);
        it.kmer_index = KMER_W'(kmer);
        it.prob_value = value;
        it.last       = last;
        send_item(it);
    endtask

    // Unused fields of a query carry random noise.
    task automatic send_query(input int kmer, input bit last);
        t_kmer_item it;
        it.func       = FUNC_QUERY;
        it.class_row  = ROW_W'($urandom);
        it.kmer_index = KMER_W'(kmer);
        it.prob_value = $urandom;
        it.last       = last;
        send_item(it);
    endtask

    function automatic int pattern_word(input t_col_pattern pat, input int row, input int flat);
        case (pat)
            PAT_ZERO:       return 0;
            PAT_PEAK_LAST:  return (row == NUM_CLASSES - 1) ? 32'h7FFF_FFFF : row - 1000;
            PAT_MIN_TIE:    return (row == 5 || row == 9) ? -1 : 32'h8000_0000;
            PAT_ALT:        return (row % 2) ? 32'hAAAA_AAAA : 32'h5555_5555;
            PAT_RAND_FULL:  return $urandom;
            PAT_RAND_SMALL: return int'($urandom_range(4)) - 2;
            PAT_EXTREME: begin
                case ($urandom_range(3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            default:        return flat;
        endcase
    endfunction

    function automatic int out_of_range_kmer();
        return $urandom_range(1) ? 0 : $urandom_range(KMER_MAX_CODE, NUM_KMERS + 1);
    endfunction

    // Writes all rows of one column in a scrambled row order.
    task automatic fill_column(input int kmer, input t_col_pattern pat);
        int step;
        int start;
        int flat;
        int row;
        step  = 2 * $urandom_range(NUM_CLASSES / 2 - 1) + 1;
        start = $urandom_range(NUM_CLASSES - 1);
        flat  = $urandom;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            row = (start + k * step) % NUM_CLASSES;
            send_write(row, kmer, pattern_word(pat, row, flat), $urandom_range(1));
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (best_class_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_table_load();
        fill_column(1, PAT_ZERO);
        fill_column(2, PAT_PEAK_LAST);
        fill_column(3, PAT_MIN_TIE);
        fill_column(NUM_KMERS, PAT_ALT);
        drain();
    endtask

    task automatic test_directed_queries();
        send_query(1, 1'b1);
        send_query(2, 1'b1);
        send_query(3, 1'b1);
        send_query(NUM_KMERS, 1'b1);
        // sums grow past 32 bits
        repeat (3) send_query(2, 1'b0);
        send_query(2, 1'b1);
        send_query(2, 1'b0);
        send_query(3, 1'b1);
        // last is ignored on a table write
        send_write(10, 1, 5, 1'b1);
        send_query(1, 1'b1);
        drain();
    endtask

    task automatic test_out_of_range();
        // would alias onto columns 1, NUM_KMERS and NUM_KMERS - 1 if the index wrapped
        send_write(3, NUM_KMERS + 1, 32'h7FFF_FFFF, 1'b1);
        send_write(NUM_CLASSES - 1, 0, 32'h7FFF_FFFF, 1'b1);
        send_write(7, KMER_MAX_CODE, 32'h7FFF_FFFF, 1'b0);
        send_query(1, 1'b1);
        send_query(NUM_KMERS, 1'b1);
        send_query(0, 1'b1);
        send_query(NUM_KMERS + 1, 1'b0);
        send_query(2, 1'b0);
        send_query(KMER_MAX_CODE, 1'b1);
        drain();
    endtask

    task automatic test_output_backpressure();
        rx_hold_req = ~rx_hold_req;
        repeat (12) send_query(full_cols[$urandom_range(full_cols.size() - 1)], 1'b1);
        drain();
    endtask

    task automatic test_random_traffic();
        int items;
        int kind;
        int n;
        int col;
        items = 0;
        while (items < RAND_ITEMS) begin
            idle_on = !(items >= 500 && items < 800);
            kind    = $urandom_range(99);
            if (kind < 6) begin
                if ($urandom_range(9) == 0)
                    col = $urandom_range(1) ? 1 : NUM_KMERS;
                else
                    col = $urandom_range(NUM_KMERS, 1);
                fill_column(col, t_col_pattern'($urandom_range(PAT_FLAT, PAT_RAND_FULL)));
                items += NUM_CLASSES;
            end else if (kind < 16) begin
                n = $urandom_range(4, 1);
                repeat (n) begin
                    col = full_cols[$urandom_range(full_cols.size() - 1)];
                    send_write($urandom_range(NUM_CLASSES - 1), col,
                               $urandom_range(1) ? pattern_word(PAT_EXTREME, 0, 0) : $urandom,
                               $urandom_range(1));
                end
                items += n;
            end else if (kind < 21) begin
                repeat ($urandom_range(3, 1))
                    send_write($urandom_range(NUM_CLASSES - 1), out_of_range_kmer(),
                               $urandom, $urandom_range(1));
            end else begin
                n = $urandom_range(6, 1);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(9) == 0)
                        col = out_of_range_kmer();
                    else
                        col = full_cols[$urandom_range(full_cols.size() - 1)];
                    send_query(col, k == n - 1);
                end
                items += n;
            end
        end
        idle_on = 1'b1;
        drain();
    endtask

    initial begin
        in_if.valid      = 1'b0;
        in_if.func       = FUNC_WRITE;
        in_if.class_row  = '0;
        in_if.kmer_index = '0;
        in_if.prob_value = '0;
        in_if.last       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_table_load();
        test_directed_queries();
        test_out_of_range();
        test_output_backpressure();
        test_random_traffic();
        if (err_cnt == 0)
            $display("tb_kmer_naive_bayes_classifier_unit: clean");
        else
            $display("tb_kmer_naive_bayes_classifier_unit: errors");
        $finish;
    end

    // Result receiver: random stalls plus a long hold-off on request.
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left    = 0;
        hold_seen    = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != hold_seen) begin
                hold_seen = rx_hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !(idle_on && $urandom_range(99) < 18);
            end
        end
    end

    always @(posedge i_clk) begin
        logic [BEST_W-1:0] want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (best_class_q.size() == 0) begin
                $error("best_class: unexpected transfer, actual %0d", out_if.best_class);
                err_cnt++;
            end else begin
                want = best_class_q.pop_front();
                if (out_if.best_class !== want) begin
                    $error("best_class: expected %0d, actual %0d", want, out_if.best_class);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb_kmer_naive_bayes_classifier_unit: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- files.f -----
rtl/knb_pkg.sv
rtl/knb_channels.sv
rtl/knb_table_ram.sv
rtl/knb_accum.sv
rtl/kmer_naive_bayes_classifier_unit.sv
sim/tb_kmer_naive_bayes_classifier_unit.sv
